// ----- src/clex_pkg.sv -----
// Shared types and constants for the C-subset lexer.
// Used by clex_core and c_subset_lexer; no dependencies.
package clex_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 16;

    // Token kinds
    localparam logic [5:0] K_END     = 6'd0;
    localparam logic [5:0] K_LPAREN  = 6'd1;
    localparam logic [5:0] K_RPAREN  = 6'd2;
    localparam logic [5:0] K_LBRACE  = 6'd3;
    localparam logic [5:0] K_RBRACE  = 6'd4;
    localparam logic [5:0] K_COMMA   = 6'd5;
    localparam logic [5:0] K_SEMI    = 6'd6;
    localparam logic [5:0] K_DOT     = 6'd7;
    localparam logic [5:0] K_ARROW   = 6'd8;
    localparam logic [5:0] K_SLASH   = 6'd9;
    localparam logic [5:0] K_STAR    = 6'd10;
    localparam logic [5:0] K_PLUS    = 6'd11;
    localparam logic [5:0] K_MINUS   = 6'd12;
    localparam logic [5:0] K_AMP     = 6'd13;
    localparam logic [5:0] K_OROR    = 6'd14;
    localparam logic [5:0] K_BAR     = 6'd15;
    localparam logic [5:0] K_CARET   = 6'd16;
    localparam logic [5:0] K_BANG    = 6'd17;
    localparam logic [5:0] K_NE      = 6'd18;
    localparam logic [5:0] K_TILDE   = 6'd19;
    localparam logic [5:0] K_EQEQ    = 6'd20;
    localparam logic [5:0] K_ASSIGN  = 6'd21;
    localparam logic [5:0] K_GE      = 6'd22;
    localparam logic [5:0] K_GT      = 6'd23;
    localparam logic [5:0] K_LE      = 6'd24;
    localparam logic [5:0] K_LT      = 6'd25;
    localparam logic [5:0] K_CHAR    = 6'd26;
    localparam logic [5:0] K_STRING  = 6'd27;
    localparam logic [5:0] K_NUMBER  = 6'd28;
    localparam logic [5:0] K_IDENT   = 6'd29;
    localparam logic [5:0] K_ERROR   = 6'd40;

    // Error codes
    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_BAD_CHAR   = 3'd1;
    localparam logic [2:0] E_BAD_ESC    = 3'd2;
    localparam logic [2:0] E_DIRECTIVE  = 3'd3;
    localparam logic [2:0] E_UNKNOWN    = 3'd4;
    localparam logic [2:0] E_UNTERM_STR = 3'd5;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } t_lex_in;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [2:0]  error_code;
        logic [19:0] src_line;
        logic [23:0] start_offset;
        logic [15:0] token_length;
        logic [7:0]  char_value;
        logic        is_last;
    } t_lex_out;

    // Tokens produced by one byte, in order
    typedef struct packed {
        logic [1:0]             cnt;
        t_lex_out [MAX_RES-1:0] tok;
    } t_res_group;

endpackage

// ----- src/clex_core.sv -----
// Lexer state and per-byte next-state logic; emits up to three tokens per byte.
// Depends on clex_pkg.
module clex_core #(
    parameter int LINE_BITS   = clex_pkg::LINE_BITS_DEF,
    parameter int OFFSET_BITS = clex_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = clex_pkg::LENGTH_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  clex_pkg::t_lex_in    i_item,
    output clex_pkg::t_res_group o_res
);
    import clex_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_MINUS, M_BAR, M_BANG, M_EQ, M_GT, M_LT,
        M_NUMBER, M_IDENT, M_CHAR_OPEN, M_CHAR_BODY, M_STRING, M_STRING_ESC, M_HALT
    } t_mode;

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

    // Keyword spellings are stored byte-reversed so byte 0 is the first letter
    localparam logic [63:0] KW_WORD [10] = '{
        64'("fi"), 64'("rof"), 64'("esle"), 64'("mune"), 64'("elihw"),
        64'("tsnoc"), 64'("nruter"), 64'("citats"), 64'("tcurts"), 64'("fedepyt")
    };
    localparam logic [2:0] KW_LEN [10] = '{
        3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd7
    };

    t_mode                   r_mode, n_mode;
    logic [LINE_BITS-1:0]    r_line, n_line;
    logic [OFFSET_BITS-1:0]  r_off, n_off;
    logic [OFFSET_BITS-1:0]  r_tstart, n_tstart;
    logic [LINE_BITS-1:0]    r_tline, n_tline;
    logic [LENGTH_BITS-1:0]  r_len, n_len;
    logic [7:0][7:0]         r_kw, n_kw;
    logic [7:0]              r_lit, n_lit;

    t_lex_out [MAX_RES-1:0]  res;
    logic [1:0]              nres;
    logic [7:0]              c;
    logic                    eot;
    logic                    to_idle;
    logic [7:0]              second;

    function automatic t_lex_out mk(input logic [5:0] kind, input logic [2:0] err,
                                    input logic [LINE_BITS-1:0] line,
                                    input logic [OFFSET_BITS-1:0] start,
                                    input logic [LENGTH_BITS-1:0] len,
                                    input logic [7:0] cv, input logic last);
        t_lex_out t;
        t.token_kind   = kind;
        t.error_code   = err;
        t.src_line     = 20'(line);
        t.start_offset = 24'(start);
        t.token_length = 16'(len);
        t.char_value   = cv;
        t.is_last      = last;
        return t;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [LENGTH_BITS-1:0] len,
                                              input logic [7:0][7:0] kw);
        logic [5:0]  k;
        logic [63:0] m;
        k = K_IDENT;
        for (int i = 9; i >= 0; i--) begin
            m = (64'd1 << (8 * KW_LEN[i])) - 64'd1;
            if (len == LENGTH_BITS'(KW_LEN[i]) && ((kw ^ KW_WORD[i]) & m) == 64'd0) begin
                k = 6'(30 + i);
            end
        end
        return k;
    endfunction

    function automatic logic [5:0] pending_single(input t_mode m);
        case (m)
            M_MINUS: return K_MINUS;
            M_BAR:   return K_BAR;
            M_BANG:  return K_BANG;
            M_EQ:    return K_ASSIGN;
            M_GT:    return K_GT;
            default: return K_LT;
        endcase
    endfunction

    function automatic logic [5:0] pair_kind(input t_mode m);
        case (m)
            M_MINUS: return K_ARROW;
            M_BAR:   return K_OROR;
            M_BANG:  return K_NE;
            M_EQ:    return K_EQEQ;
            M_GT:    return K_GE;
            default: return K_LE;
        endcase
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] l);
        return (l == '1) ? l : l + LEN_ONE;
    endfunction

    // Per-byte next state and token list
    always_comb begin
        c        = i_item.char_in;
        eot      = i_item.end_of_text;
        n_mode   = r_mode;
        n_line   = r_line;
        n_off    = r_off;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_len    = r_len;
        n_kw     = r_kw;
        n_lit    = r_lit;
        res      = '0;
        nres     = 2'd0;
        to_idle  = 1'b0;
        second   = (r_mode == M_MINUS) ? ">" : ((r_mode == M_BAR) ? "|" : "=");

        if (r_mode == M_HALT) begin
            if (eot) begin
                n_mode   = M_IDLE;
                n_line   = LINE_ONE;
                n_off    = '0;
                n_tstart = '0;
                n_tline  = LINE_ONE;
                n_len    = '0;
                n_lit    = '0;
            end
        end else begin
            // finish or extend the token in progress
            case (r_mode)
                M_MINUS, M_BAR, M_BANG, M_EQ, M_GT, M_LT: begin
                    n_mode = M_IDLE;
                    if (c == second) begin
                        n_len = LENGTH_BITS'(2);
                        res[nres] = mk(pair_kind(r_mode), E_NONE, r_tline, r_tstart,
                                       LENGTH_BITS'(2), 8'd0, 1'b0);
                        nres = nres + 2'd1;
                    end else begin
                        res[nres] = mk(pending_single(r_mode), E_NONE, r_tline, r_tstart,
                                       r_len, 8'd0, 1'b0);
                        nres = nres + 2'd1;
                        to_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_num(c) || c == ".") begin
                        n_len = len_inc(r_len);
                    end else begin
                        res[nres] = mk(K_NUMBER, E_NONE, r_tline, r_tstart, r_len,
                                       8'd0, 1'b0);
                        nres = nres + 2'd1;
                        n_mode = M_IDLE;
                        to_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_num(c)) begin
                        if (r_len < LENGTH_BITS'(8)) begin
                            n_kw[r_len[2:0]] = c;
                        end
                        n_len = len_inc(r_len);
                    end else begin
                        res[nres] = mk(ident_kind(r_len, r_kw), E_NONE, r_tline, r_tstart,
                                       r_len, 8'd0, 1'b0);
                        nres = nres + 2'd1;
                        n_mode = M_IDLE;
                        to_idle = 1'b1;
                    end
                end
                M_CHAR_OPEN: begin
                    n_lit  = c;
                    n_len  = LENGTH_BITS'(2);
                    n_mode = M_CHAR_BODY;
                end
                M_CHAR_BODY: begin
                    if (c == "'") begin
                        n_len = LENGTH_BITS'(3);
                        res[nres] = mk(K_CHAR, E_NONE, r_tline, r_tstart,
                                       LENGTH_BITS'(3), r_lit, 1'b0);
                        nres = nres + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[nres] = mk(K_ERROR, E_BAD_CHAR, r_tline, r_tstart, '0,
                                       8'd0, 1'b1);
                        nres = nres + 2'd1;
                        n_mode = M_HALT;
                    end
                end
                M_STRING: begin
                    n_len = len_inc(r_len);
                    if (c == "\\") begin
                        n_mode = M_STRING_ESC;
                    end else if (c == "\"") begin
                        res[nres] = mk(K_STRING, E_NONE, r_tline, r_tstart, n_len,
                                       8'd0, 1'b0);
                        nres = nres + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_STRING_ESC: begin
                    if (c == "n" || c == "r" || c == "t" || c == "\"") begin
                        n_len  = len_inc(r_len);
                        n_mode = M_STRING;
                    end else begin
                        res[nres] = mk(K_ERROR, E_BAD_ESC, r_tline, r_tstart, '0,
                                       8'd0, 1'b1);
                        nres = nres + 2'd1;
                        n_mode = M_HALT;
                    end
                end
                default: begin
                    to_idle = 1'b1;
                end
            endcase

            // byte seen from idle: skip, single, start a token, or error
            if (to_idle) begin
                case (c)
                    "\n", " ", "\t": begin
                    end
                    "(", ")", "{", "}", ",", ";", ".", "/", "*", "+", "&", "^", "~": begin
                        res[nres] = mk(
                            (c == "(") ? K_LPAREN : (c == ")") ? K_RPAREN :
                            (c == "{") ? K_LBRACE : (c == "}") ? K_RBRACE :
                            (c == ",") ? K_COMMA  : (c == ";") ? K_SEMI   :
                            (c == ".") ? K_DOT    : (c == "/") ? K_SLASH  :
                            (c == "*") ? K_STAR   : (c == "+") ? K_PLUS   :
                            (c == "&") ? K_AMP    : (c == "^") ? K_CARET  : K_TILDE,
                            E_NONE, r_line, r_off, LEN_ONE, 8'd0, 1'b0);
                        nres = nres + 2'd1;
                    end
                    "-", "|", "!", "=", ">", "<", "'", "\"": begin
                        n_tstart = r_off;
                        n_tline  = r_line;
                        n_len    = LEN_ONE;
                        n_mode   = (c == "-") ? M_MINUS : (c == "|") ? M_BAR :
                                   (c == "!") ? M_BANG  : (c == "=") ? M_EQ  :
                                   (c == ">") ? M_GT    : (c == "<") ? M_LT  :
                                   (c == "'") ? M_CHAR_OPEN : M_STRING;
                    end
                    default: begin
                        if (is_num(c) || is_alpha(c)) begin
                            n_tstart = r_off;
                            n_tline  = r_line;
                            n_len    = LEN_ONE;
                            n_mode   = is_num(c) ? M_NUMBER : M_IDENT;
                            n_kw[0]  = c;
                        end else begin
                            res[nres] = mk(K_ERROR, (c == "#") ? E_DIRECTIVE : E_UNKNOWN,
                                           r_line, r_off, '0, 8'd0, 1'b1);
                            nres = nres + 2'd1;
                            n_mode = M_HALT;
                        end
                    end
                endcase
            end

            // position counters saturate
            if (c == "\n" && r_line != '1) begin
                n_line = r_line + LINE_ONE;
            end
            if (r_off != '1) begin
                n_off = r_off + OFFSET_BITS'(1);
            end

            // end of text: flush the open token, then the end marker if no error, restart
            if (eot) begin
                case (n_mode)
                    M_MINUS, M_BAR, M_BANG, M_EQ, M_GT, M_LT: begin
                        res[nres] = mk(pending_single(n_mode), E_NONE, n_tline, n_tstart,
                                       n_len, 8'd0, 1'b0);
                        nres = nres + 2'd1;
                    end
                    M_NUMBER: begin
                        res[nres] = mk(K_NUMBER, E_NONE, n_tline, n_tstart, n_len,
                                       8'd0, 1'b0);
                        nres = nres + 2'd1;
                    end
                    M_IDENT: begin
                        res[nres] = mk(ident_kind(n_len, n_kw), E_NONE, n_tline, n_tstart,
                                       n_len, 8'd0, 1'b0);
                        nres = nres + 2'd1;
                    end
                    M_CHAR_OPEN, M_CHAR_BODY: begin
                        res[nres] = mk(K_ERROR, E_BAD_CHAR, n_tline, n_tstart, '0,
                                       8'd0, 1'b1);
                        nres = nres + 2'd1;
                    end
                    M_STRING, M_STRING_ESC: begin
                        res[nres] = mk(K_ERROR, E_UNTERM_STR, n_tline, n_tstart, '0,
                                       8'd0, 1'b1);
                        nres = nres + 2'd1;
                    end
                    default: begin
                    end
                endcase
                if (n_mode == M_IDLE || n_mode == M_MINUS || n_mode == M_BAR ||
                    n_mode == M_BANG || n_mode == M_EQ || n_mode == M_GT ||
                    n_mode == M_LT || n_mode == M_NUMBER || n_mode == M_IDENT) begin
                    res[nres] = mk(K_END, E_NONE, n_line, n_off, '0, 8'd0, 1'b1);
                    nres = nres + 2'd1;
                end
                n_mode   = M_IDLE;
                n_line   = LINE_ONE;
                n_off    = '0;
                n_tstart = '0;
                n_tline  = LINE_ONE;
                n_len    = '0;
                n_lit    = '0;
            end
        end
    end

    assign o_res.cnt = i_accept ? nres : 2'd0;
    assign o_res.tok = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_line   <= LINE_ONE;
            r_off    <= '0;
            r_tstart <= '0;
            r_tline  <= LINE_ONE;
            r_len    <= '0;
            r_lit    <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_off    <= n_off;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_len    <= n_len;
            r_lit    <= n_lit;
        end
    end

    // Keyword buffer: payload only
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_kw <= n_kw;
        end
    end

endmodule

// ----- src/c_subset_lexer.sv -----
// Top level of the C-subset lexer: input handshake, lexer core, token queue.
// Depends on clex_pkg and clex_core.
//
// Usage: one source byte per input transaction on i_in_*, with end_of_text set
// on the last byte of a text. Tokens leave on o_out_* one per transaction, in
// source order, each with kind, line, start offset, length and char value.
// A byte completes zero to three tokens; they enter a four-entry queue in the
// cycle the byte is accepted and, if the queue was empty, the first is offered
// the next cycle; otherwise they wait behind the tokens already queued.
// Throughput: one byte per cycle while the queue holds at most one token; the
// queue depth sets this, so a byte yielding several tokens, or a stalled
// receiver, holds off input until the queue drains below two entries.
// After an error token, bytes are consumed silently until end_of_text.
// Reset (synchronous, active low) empties the queue and returns the lexer to
// line 1, offset 0. While the receiver stalls, the offered token holds.
module c_subset_lexer #(
    parameter int LINE_BITS   = clex_pkg::LINE_BITS_DEF,
    parameter int OFFSET_BITS = clex_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = clex_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  clex_pkg::t_lex_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output clex_pkg::t_lex_out o_out_data
);
    import clex_pkg::*;

    logic       accept;
    logic       pop;
    t_res_group grp;

    t_lex_out   r_fifo [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;

    assign o_in_ready  = (r_cnt <= 3'd1);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_fifo[r_rd];
    assign pop         = o_out_valid && i_out_ready;

    clex_core #(
        .LINE_BITS  (LINE_BITS),
        .OFFSET_BITS(OFFSET_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_data),
        .o_res   (grp)
    );

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + grp.cnt;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, grp.cnt} - {2'b00, pop};
        end
    end

    // Queue storage: up to three tokens written per cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < grp.cnt) begin
                r_fifo[r_wr + 2'(k)] <= grp.tok[k];
            end
        end
    end

endmodule

// ----- bench/c_subset_lexer_test.sv -----
// Self-checking C-subset lexer bench: directed bytes and text, hold-off, then random text.
// Tokens are predicted in-bench and compared in order. Depends on clex_pkg, c_subset_lexer.
module c_subset_lexer_test;
    import clex_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MINUS, S_BAR, S_BANG, S_EQ, S_GT, S_LT,
        S_NUMBER, S_IDENT, S_CHAR_OPEN, S_CHAR_BODY, S_STRING, S_STRING_ESC, S_HALT
    } t_scan;

    localparam logic [19:0] LINE_MAX = '1;
    localparam logic [23:0] OFS_MAX  = '1;
    localparam logic [15:0] LEN_MAX  = '1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_lex_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_lex_out o_out_data;

    c_subset_lexer DUT (.*);

    always #5 i_clk = ~i_clk;

    // Lexer shadow state
    t_scan       lx_mode = S_IDLE;
    logic [19:0] lx_line = 20'd1, lx_tline = 20'd1;
    logic [23:0] lx_ofs = 24'd0, lx_tstart = 24'd0;
    logic [15:0] lx_tlen = 16'd0;
    logic [7:0]  lx_kw [8];
    logic [7:0]  lx_lit = 8'd0;

    t_lex_out tokens_due[$];
    t_lex_out first_new;
    bit  first_new_ok = 0;
    int  errors = 0;
    bit  stim_done = 0;
    bit  no_idle = 0;
    bit  hold_off = 0;

    function automatic t_lex_out tok(logic [5:0] k, logic [2:0] e, logic [19:0] l,
                                     logic [23:0] s, logic [15:0] n, logic [7:0] cv,
                                     logic last);
        t_lex_out t;
        t.token_kind = k; t.error_code = e; t.src_line = l;
        t.start_offset = s; t.token_length = n; t.char_value = cv; t.is_last = last;
        return t;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alp(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic bit kw_is(string w);
        if (lx_tlen != w.len()) return 0;
        for (int i = 0; i < w.len(); i++)
            if (lx_kw[i] != w[i]) return 0;
        return 1;
    endfunction

    function automatic logic [5:0] word_kind();
        if (kw_is("if"))      return 6'd30;
        if (kw_is("for"))     return 6'd31;
        if (kw_is("else"))    return 6'd32;
        if (kw_is("enum"))    return 6'd33;
        if (kw_is("while"))   return 6'd34;
        if (kw_is("const"))   return 6'd35;
        if (kw_is("return"))  return 6'd36;
        if (kw_is("static"))  return 6'd37;
        if (kw_is("struct"))  return 6'd38;
        if (kw_is("typedef")) return 6'd39;
        return K_IDENT;
    endfunction

    function automatic logic [5:0] lone_kind(t_scan m);
        case (m)
            S_MINUS: return K_MINUS;
            S_BAR:   return K_BAR;
            S_BANG:  return K_BANG;
            S_EQ:    return K_ASSIGN;
            S_GT:    return K_GT;
            default: return K_LT;
        endcase
    endfunction

    function automatic void lex_reset();
        lx_mode = S_IDLE; lx_line = 20'd1; lx_ofs = 24'd0; lx_tstart = 24'd0;
        lx_tline = 20'd1; lx_tlen = 16'd0; lx_lit = 8'd0;
    endfunction

    function automatic void push_tok(logic [5:0] k);
        tokens_due.push_back(tok(k, E_NONE, lx_tline, lx_tstart, lx_tlen, 8'd0, 1'b0));
    endfunction

    function automatic void lit_error(logic [2:0] e);
        tokens_due.push_back(tok(K_ERROR, e, lx_tline, lx_tstart, 16'd0, 8'd0, 1'b1));
        lx_mode = S_HALT;
    endfunction

    function automatic void open_tok(t_scan m);
        lx_tstart = lx_ofs; lx_tline = lx_line; lx_tlen = 16'd1; lx_mode = m;
    endfunction

    // Byte seen from the idle state
    function automatic void lex_idle(logic [7:0] c);
        logic [5:0] k;
        k = 6'd0;
        case (c)
            "\n", " ", "\t": return;
            "(": k = K_LPAREN;  ")": k = K_RPAREN;  "{": k = K_LBRACE;
            "}": k = K_RBRACE;  ",": k = K_COMMA;   ";": k = K_SEMI;
            ".": k = K_DOT;     "/": k = K_SLASH;   "*": k = K_STAR;
            "+": k = K_PLUS;    "&": k = K_AMP;     "^": k = K_CARET;
            "~": k = K_TILDE;
            "-": begin open_tok(S_MINUS); return; end
            "|": begin open_tok(S_BAR); return; end
            "!": begin open_tok(S_BANG); return; end
            "=": begin open_tok(S_EQ); return; end
            ">": begin open_tok(S_GT); return; end
            "<": begin open_tok(S_LT); return; end
            "'": begin open_tok(S_CHAR_OPEN); return; end
            "\"": begin open_tok(S_STRING); return; end
            default: ;
        endcase
        if (k != 6'd0) begin
            tokens_due.push_back(tok(k, E_NONE, lx_line, lx_ofs, 16'd1, 8'd0, 1'b0));
        end else if (is_dig(c)) begin
            open_tok(S_NUMBER);
        end else if (is_alp(c)) begin
            open_tok(S_IDENT);
            lx_kw[0] = c;
        end else begin
            tokens_due.push_back(tok(K_ERROR, (c == "#") ? E_DIRECTIVE : E_UNKNOWN,
                                     lx_line, lx_ofs, 16'd0, 8'd0, 1'b1));
            lx_mode = S_HALT;
        end
    endfunction

    // Predict the tokens that one accepted byte completes
    function automatic void lex_byte(t_lex_in b);
        logic [7:0] c;
        logic [7:0] second;
        bit fall;
        int q0;
        c = b.char_in;
        fall = 0;
        q0 = tokens_due.size();
        first_new_ok = 0;
        if (lx_mode == S_HALT) begin
            if (b.end_of_text) lex_reset();
            return;
        end
        case (lx_mode)
            S_MINUS, S_BAR, S_BANG, S_EQ, S_GT, S_LT: begin
                second = (lx_mode == S_MINUS) ? ">" : (lx_mode == S_BAR) ? "|" : "=";
                if (c == second) begin
                    lx_tlen = 16'd2;
                    case (lx_mode)
                        S_MINUS: push_tok(K_ARROW);
                        S_BAR:   push_tok(K_OROR);
                        S_BANG:  push_tok(K_NE);
                        S_EQ:    push_tok(K_EQEQ);
                        S_GT:    push_tok(K_GE);
                        default: push_tok(K_LE);
                    endcase
                end else begin
                    push_tok(lone_kind(lx_mode));
                    fall = 1;
                end
                lx_mode = S_IDLE;
            end
            S_NUMBER:
                if (is_dig(c) || c == ".") begin
                    if (lx_tlen < LEN_MAX) lx_tlen++;
                end else begin
                    push_tok(K_NUMBER); lx_mode = S_IDLE; fall = 1;
                end
            S_IDENT:
                if (is_alp(c) || is_dig(c)) begin
                    if (lx_tlen < 8) lx_kw[lx_tlen[2:0]] = c;
                    if (lx_tlen < LEN_MAX) lx_tlen++;
                end else begin
                    push_tok(word_kind()); lx_mode = S_IDLE; fall = 1;
                end
            S_CHAR_OPEN: begin
                lx_lit = c; lx_tlen = 16'd2; lx_mode = S_CHAR_BODY;
            end
            S_CHAR_BODY:
                if (c == "'") begin
                    lx_tlen = 16'd3;
                    tokens_due.push_back(tok(K_CHAR, E_NONE, lx_tline, lx_tstart, 16'd3,
                                             lx_lit, 1'b0));
                    lx_mode = S_IDLE;
                end else begin
                    lit_error(E_BAD_CHAR);
                end
            S_STRING: begin
                if (lx_tlen < LEN_MAX) lx_tlen++;
                if (c == "\\") lx_mode = S_STRING_ESC;
                else if (c == "\"") begin
                    push_tok(K_STRING); lx_mode = S_IDLE;
                end
            end
            S_STRING_ESC:
                if (c == "n" || c == "r" || c == "t" || c == "\"") begin
                    if (lx_tlen < LEN_MAX) lx_tlen++;
                    lx_mode = S_STRING;
                end else begin
                    lit_error(E_BAD_ESC);
                end
            default: fall = 1;
        endcase
        if (fall) lex_idle(c);
        if (c == "\n" && lx_line < LINE_MAX) lx_line++;
        if (lx_ofs < OFS_MAX) lx_ofs++;
        if (b.end_of_text) begin
            case (lx_mode)
                S_MINUS, S_BAR, S_BANG, S_EQ, S_GT, S_LT: push_tok(lone_kind(lx_mode));
                S_NUMBER: push_tok(K_NUMBER);
                S_IDENT: push_tok(word_kind());
                S_CHAR_OPEN, S_CHAR_BODY: lit_error(E_BAD_CHAR);
                S_STRING, S_STRING_ESC: lit_error(E_UNTERM_STR);
                default: ;
            endcase
            if (lx_mode != S_HALT)
                tokens_due.push_back(tok(K_END, E_NONE, lx_line, lx_ofs, 16'd0, 8'd0, 1'b1));
            lex_reset();
        end
        // first token this byte produced, for the directed table
        if (tokens_due.size() > q0) begin
            first_new = tokens_due[q0];
            first_new_ok = 1;
        end
    endfunction

    // Compare a typed-in table value with the predicted first token of its byte
    function automatic void check_row(int i, t_lex_out e);
        if (!first_new_ok) begin
            $error("row %0d: token_kind exp %0d got none", i, e.token_kind);
            errors++;
            return;
        end
        if (first_new.token_kind !== e.token_kind) begin
            $error("row %0d: token_kind exp %0d got %0d", i, e.token_kind,
                   first_new.token_kind);
            errors++;
        end
        if (first_new.error_code !== e.error_code) begin
            $error("row %0d: error_code exp %0d got %0d", i, e.error_code,
                   first_new.error_code);
            errors++;
        end
        if (first_new.src_line !== e.src_line) begin
            $error("row %0d: src_line exp %0d got %0d", i, e.src_line, first_new.src_line);
            errors++;
        end
        if (first_new.start_offset !== e.start_offset) begin
            $error("row %0d: start_offset exp %0d got %0d", i, e.start_offset,
                   first_new.start_offset);
            errors++;
        end
        if (first_new.token_length !== e.token_length) begin
            $error("row %0d: token_length exp %0d got %0d", i, e.token_length,
                   first_new.token_length);
            errors++;
        end
        if (first_new.char_value !== e.char_value) begin
            $error("row %0d: char_value exp %0d got %0d", i, e.char_value,
                   first_new.char_value);
            errors++;
        end
        if (first_new.is_last !== e.is_last) begin
            $error("row %0d: is_last exp %0d got %0d", i, e.is_last, first_new.is_last);
            errors++;
        end
    endfunction

    // Directed table: bytes with optional typed-in expectation of the first token
    typedef struct {
        logic [7:0] c;
        logic       eot;
        bit         has_exp;
        t_lex_out   exp;
    } t_row;
    t_row dir_rows[$];

    function automatic void row(logic [7:0] c, logic eot);
        t_row r;
        r.c = c; r.eot = eot; r.has_exp = 0; r.exp = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_exp(logic [7:0] c, logic eot, t_lex_out e);
        t_row r;
        r.c = c; r.eot = eot; r.has_exp = 1; r.exp = e;
        dir_rows.push_back(r);
    endfunction

    // Send one byte: valid held until accepted; returns at the next falling edge
    task automatic send_byte(logic [7:0] c, logic eot);
        t_lex_in b;
        b.char_in = c; b.end_of_text = eot;
        while (!no_idle && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        lex_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, bit terminate);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], terminate && i == s.len() - 1);
    endtask

    // Random text: mostly well-formed C fragments, some noise
    function automatic string pick_frag();
        string lex_words[18] = '{"if", "for", "else", "enum", "while", "const", "return",
            "static", "struct", "typedef", "x_1", "Struct", "typedefs", "whilE",
            "_a9", "abcdefghij", "en", "retur"};
        string ops[20] = '{"->", "||", "!=", "==", ">=", "<=", "-", "|", "!", "=", ">",
            "<", "(", ")", "{", "}", ",", ";", "*", "+"};
        string escs;
        string s;
        int k;
        escs = "nrt\"";
        k = $urandom_range(99);
        if (k < 30) s = lex_words[$urandom_range(17)];
        else if (k < 55) s = ops[$urandom_range(19)];
        else if (k < 65) s = $sformatf("%0d.%0d", $urandom_range(999), $urandom_range(9));
        else if (k < 73) begin
            s = "'";
            s = {s, string'(8'($urandom_range(255))), "'"};
        end else if (k < 82) begin
            s = "\"a";
            if ($urandom_range(1)) s = {s, "\\", string'(escs[$urandom_range(3)])};
            s = {s, "b\""};
        end else if (k < 94) s = (k & 1) ? "\n" : " \t";
        else s = "/&^~.";
        return s;
    endfunction

    // Receiver with random stalls and one long hold-off
    initial begin
        int  hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold = 60;
                while (hold > 0) begin
                    i_out_ready <= 1'b0;
                    hold--;
                    @(negedge i_clk);
                end
                hold_off = 0;
            end
            i_out_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected token kind %0d", o_out_data.token_kind);
                errors++;
            end else begin : cmp
                t_lex_out e;
                e = tokens_due.pop_front();
                if (o_out_data.token_kind !== e.token_kind) begin
                    $error("token_kind exp %0d got %0d", e.token_kind, o_out_data.token_kind);
                    errors++;
                end
                if (o_out_data.error_code !== e.error_code) begin
                    $error("error_code exp %0d got %0d", e.error_code, o_out_data.error_code);
                    errors++;
                end
                if (o_out_data.src_line !== e.src_line) begin
                    $error("src_line exp %0d got %0d", e.src_line,
                           o_out_data.src_line);
                    errors++;
                end
                if (o_out_data.start_offset !== e.start_offset) begin
                    $error("start_offset exp %0d got %0d", e.start_offset,
                           o_out_data.start_offset);
                    errors++;
                end
                if (o_out_data.token_length !== e.token_length) begin
                    $error("token_length exp %0d got %0d", e.token_length,
                           o_out_data.token_length);
                    errors++;
                end
                if (o_out_data.char_value !== e.char_value) begin
                    $error("char_value exp %0d got %0d", e.char_value, o_out_data.char_value);
                    errors++;
                end
                if (o_out_data.is_last !== e.is_last) begin
                    $error("is_last exp %0d got %0d", e.is_last, o_out_data.is_last);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int sent;
        string s;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first token after reset, extremes, error codes
        row_exp("(", 1'b0, tok(K_LPAREN, E_NONE, 20'd1, 24'd0, 16'd1, 8'd0, 1'b0));
        row_exp("\n", 1'b1, tok(K_END, E_NONE, 20'd2, 24'd2, 16'd0, 8'd0, 1'b1));
        row_exp("#", 1'b0, tok(K_ERROR, E_DIRECTIVE, 20'd1, 24'd0, 16'd0, 8'd0, 1'b1));
        row(8'hFF, 1'b1);
        row_exp(8'h00, 1'b1, tok(K_ERROR, E_UNKNOWN, 20'd1, 24'd0, 16'd0, 8'd0, 1'b1));
        row("'", 1'b0);
        row_exp(8'hFF, 1'b0, '0);
        row_exp("'", 1'b1, tok(K_CHAR, E_NONE, 20'd1, 24'd0, 16'd3, 8'hFF, 1'b0));
        row("'", 1'b0);
        row("\n", 1'b0);
        row_exp("x", 1'b0, tok(K_ERROR, E_BAD_CHAR, 20'd1, 24'd0, 16'd0, 8'd0, 1'b1));
        row("q", 1'b1);
        row("\"", 1'b0);
        row("\\", 1'b0);
        row_exp("q", 1'b0, tok(K_ERROR, E_BAD_ESC, 20'd1, 24'd0, 16'd0, 8'd0, 1'b1));
        row("z", 1'b1);
        row("\"", 1'b0);
        row_exp("\\", 1'b1, tok(K_ERROR, E_UNTERM_STR, 20'd1, 24'd0, 16'd0, 8'd0, 1'b1));
        row("'", 1'b1);
        row("7", 1'b0);
        row(".", 1'b0);
        row("-", 1'b0);
        row("<", 1'b1);
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].c, dir_rows[i].eot);
            // an all-zero typed-in value means the byte completes no token
            if (dir_rows[i].has_exp) begin
                if (dir_rows[i].exp === '0) begin
                    if (first_new_ok) begin
                        $error("row %0d: token_kind exp none got %0d", i,
                               first_new.token_kind);
                        errors++;
                    end
                end else begin
                    check_row(i, dir_rows[i].exp);
                end
            end
        end
        send_text("if for else enum while const return static struct typedef ", 0);
        send_text("a->b||c!=d==e>=f<=g-h|i!j=k>l<m{}(),;./*+&^~_Z9 \"s\\n\\r\\t\\\"\"", 1);

        // Long hold-off while input keeps coming, without idling
        no_idle = 1;
        hold_off = 1;
        send_text("a,b,c,d,e,f,g,h,i,j,k,l,m,n,o,p;", 0);
        no_idle = 0;

        // Random part
        sent = 0;
        while (sent < 136) begin
            if ($urandom_range(99) < 6) begin
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
                sent++;
            end else begin
                s = pick_frag();
                for (int i = 0; i < s.len(); i++) begin
                    send_byte(s[i], 1'b0);
                    sent++;
                end
                if ($urandom_range(15) == 0) begin
                    send_byte(" ", 1'b1);
                    sent++;
                end
                if (sent > 40 && sent < 90) no_idle = 1;
                else no_idle = 0;
            end
        end
        send_byte(";", 1'b1);
        i_in_valid <= 1'b0;
        stim_done = 1;
    end

    // End of run
    initial begin
        wait (stim_done);
        wait (tokens_due.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("c_subset_lexer_test passed");
        else
            $display("c_subset_lexer_test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("c_subset_lexer_test failed");
        $finish;
    end
endmodule
